>>> src/isqrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isqrt_pkg;

	// Field widths of the two channels; they do not follow the radicand width parameter.
	localparam int RADICAND_W = 64;
	localparam int ROOT_W     = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture a new radicand and open the search interval
		logic square;   // form the midpoint and register its square
		logic update;   // compare the square and move one bound
		logic publish;  // copy the final lower bound into the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;     // the bounds have met
	} status_t;

endpackage

`default_nettype wire

>>> src/isqrt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface isqrt_in_if;
	logic                                valid;
	logic                                ready;
	logic [isqrt_pkg::RADICAND_W-1:0]    radicand;

	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);
endinterface

interface isqrt_out_if;
	logic                            valid;
	logic                            ready;
	logic [isqrt_pkg::ROOT_W-1:0]    root;

	modport source (output valid, output root, input ready);
	modport sink   (input valid, input root, output ready);
endinterface

`default_nettype wire

>>> src/isqrt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module isqrt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire isqrt_pkg::status_t status,
	output isqrt_pkg::cmd_t         cmd
);

	typedef enum logic [1:0] {
		IDLE,
		SQUARE,
		COMPARE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			IDLE: begin
				cmd.load = in_valid;
			end
			SQUARE: begin
				if (status.done) begin
					cmd.publish = slot_free;
				end else begin
					cmd.square = 1'b1;
				end
			end
			COMPARE: begin
				cmd.update = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= SQUARE;
					end
				end
				SQUARE: begin
					if (status.done) begin
						if (slot_free) begin
							state_q <= IDLE;
						end
					end else begin
						state_q <= COMPARE;
					end
				end
				COMPARE: begin
					state_q <= SQUARE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase

			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/isqrt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module isqrt_dp #(
	parameter int INPUT_BITS = 64,
	parameter int ROOT_BITS  = 32
) (
	input  wire logic                              clk,
	input  wire logic [isqrt_pkg::RADICAND_W-1:0]  radicand,
	input  wire isqrt_pkg::cmd_t                   cmd,
	output isqrt_pkg::status_t                     status,
	output logic [isqrt_pkg::ROOT_W-1:0]           root
);

	localparam int SQ_BITS = 2 * ROOT_BITS;

	logic [ROOT_BITS-1:0]          lo_q;
	logic [ROOT_BITS-1:0]          hi_q;
	logic [ROOT_BITS-1:0]          mid_q;
	logic [SQ_BITS-1:0]            sq_q;
	logic [SQ_BITS-1:0]            val_q;
	logic [isqrt_pkg::ROOT_W-1:0]  root_q;

	logic [ROOT_BITS:0]            sum;
	logic [ROOT_BITS-1:0]          mid;

	// Rounded-up midpoint of the current bounds.
	assign sum = {1'b0, lo_q} + {1'b0, hi_q} + (ROOT_BITS + 1)'(1);
	assign mid = sum[ROOT_BITS:1];

	assign status.done = (lo_q == hi_q);
	assign root        = root_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= SQ_BITS'(radicand[INPUT_BITS-1:0]);
			lo_q  <= '0;
			hi_q  <= '1;
		end
		if (cmd.square) begin
			mid_q <= mid;
			sq_q  <= SQ_BITS'(mid) * SQ_BITS'(mid);
		end
		if (cmd.update) begin
			if (sq_q > val_q) begin
				hi_q <= mid_q - ROOT_BITS'(1);
			end else begin
				lo_q <= mid_q;
			end
		end
		if (cmd.publish) begin
			root_q <= isqrt_pkg::ROOT_W'(lo_q);
		end
	end

endmodule

`default_nettype wire

>>> src/integer_square_root_core.sv
// Each accepted radicand beat runs a binary search for its root and ends in a valid
// root beat, with ROOT_BITS = (INPUT_BITS+1)/2.
// A new radicand is taken only after the previous search has published its root; each
// search round has a step in the squaring multiplier and a step in the compare.
// Reset: arst_n clears the controller and the output valid flag asynchronously.
`timescale 1ns / 1ps
`default_nettype none

module integer_square_root_core #(
	parameter int INPUT_BITS = 64
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	isqrt_in_if.sink     req,
	isqrt_out_if.source  rsp
);

	// The root needs half the radicand bits, rounded up.
	localparam int ROOT_BITS = (INPUT_BITS + 1) / 2;

	isqrt_pkg::cmd_t    cmd;
	isqrt_pkg::status_t status;

	// The controller sequences each search: it takes a radicand beat only when idle,
	// alternates between a squaring state and a compare state until the datapath
	// reports that the bounds have met, and then hands the lower bound to the output
	// register once it is free. The output register holds the root beat until the sink
	// takes it, so a new radicand may be accepted while the previous root still waits.
	isqrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath keeps the search bounds, one multiplier that squares the
	// rounded-up midpoint, a registered square and the wide compare against the
	// masked radicand. Radicand bits above INPUT_BITS are dropped on capture.
	isqrt_dp #(
		.INPUT_BITS (INPUT_BITS),
		.ROOT_BITS  (ROOT_BITS)
	) u_dp (
		.clk      (clk),
		.radicand (req.radicand),
		.cmd      (cmd),
		.status   (status),
		.root     (rsp.root)
	);

	// A publish always raises the output valid flag in the following cycle.
	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> rsp.valid)
		else $error("root beat not presented after publish");

	// The controller issues at most one datapath command per cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.square, cmd.update, cmd.publish}))
		else $error("conflicting datapath commands");

	// Once a radicand is taken, no other is taken until its search completes.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("radicand accepted while a search is running");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	// The block is built at its default radicand width, and the predictor follows the same
	// width so that any masking of high radicand bits is modeled too.
	localparam int                               INPUT_BITS  = 64;
	localparam int                               ROOT_BITS   = (INPUT_BITS + 1) / 2;
	localparam logic [isqrt_pkg::RADICAND_W-1:0] IN_MASK     = (INPUT_BITS >= 64) ? '1 :
		((64'd1 << INPUT_BITS) - 64'd1);
	localparam logic [isqrt_pkg::RADICAND_W-1:0] ROOT_MAX    = (64'd1 << ROOT_BITS) - 64'd1;

	// The tail wait at the end of the test runs a little past LATENCY_CYCLES.
	localparam int LATENCY_CYCLES = 2 * ROOT_BITS + 1;
	localparam int RANDOM_BEATS   = 1700;
	localparam int CYCLE_LIMIT    = 1_000_000;

	// Receiver schedule, in cycles after reset release: one long hold-off while the sender
	// keeps offering radicands, and one long stretch with ready held high.
	localparam int HOLD_START     = 12000;
	localparam int HOLD_CYCLES    = 600;
	localparam int STEADY_START   = 40000;
	localparam int STEADY_END     = 60000;

	// Sender schedule, in random beat indexes: a stretch with valid held high and one
	// point where the sender waits for every pending root to come back.
	localparam int SEND_STEADY_LO = 700;
	localparam int SEND_STEADY_HI = 950;
	localparam int DRAIN_POINT    = 1200;

	// Holds the roots that accepted radicands must produce, oldest first, and checks each
	// root beat against the oldest one.
	class root_scoreboard;
		logic [isqrt_pkg::ROOT_W-1:0] pending_roots[$];
		int                           failures;

		// Binary search for the largest r with r*r <= radicand over 0 .. 2^ROOT_BITS-1.
		function logic [isqrt_pkg::ROOT_W-1:0] floor_root(
			logic [isqrt_pkg::RADICAND_W-1:0] radicand);
			logic [isqrt_pkg::RADICAND_W-1:0] value;
			logic [isqrt_pkg::RADICAND_W-1:0] lo;
			logic [isqrt_pkg::RADICAND_W-1:0] hi;
			logic [isqrt_pkg::RADICAND_W-1:0] mid;
			value = radicand & IN_MASK;
			lo = '0;
			hi = ROOT_MAX;
			while (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				if (mid * mid > value) begin
					hi = mid - 64'd1;
				end else begin
					lo = mid;
				end
			end
			return lo[isqrt_pkg::ROOT_W-1:0];
		endfunction

		function void note_radicand(logic [isqrt_pkg::RADICAND_W-1:0] radicand);
			pending_roots.push_back(floor_root(radicand));
		endfunction

		function void check_root(logic [isqrt_pkg::ROOT_W-1:0] got);
			logic [isqrt_pkg::ROOT_W-1:0] want;
			if (pending_roots.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected root beat %0d with no radicand pending", got);
				return;
			end
			want = pending_roots.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display("root mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	isqrt_in_if  req_if ();
	isqrt_out_if rsp_if ();

	integer_square_root_core #(
		.INPUT_BITS(INPUT_BITS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	root_scoreboard roots;

	// Radicands at the edges of the search: zero, tiny values, perfect squares and their
	// neighbors, the square of the largest root, the top of the range, and bit patterns.
	logic [isqrt_pkg::RADICAND_W-1:0] corner_radicands[22] = '{
		64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd8, 64'd9, 64'd15, 64'd16,
		64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
		64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0000, 64'hFFFF_FFFE_0000_0002,
		64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
		64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF,
		64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h3FFF_FFFF_0000_0001
	};

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a correct run finishes far below this many cycles.
	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Both channels are observed at the clock edge, before any driver update of this step
	// lands, so a beat is counted exactly when valid and ready were both high at the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				roots.note_radicand(req_if.radicand);
			if (rsp_if.valid && rsp_if.ready)
				roots.check_root(rsp_if.root);
		end
	end

	// Receiver. Ready drops about eight percent of the time, except during the
	// steady window. Once, it holds off for a long stretch so that the core fills up with
	// a finished root and has to refuse new radicands.
	initial begin
		int rx_cycle;
		rsp_if.ready = 1'b0;
		rx_cycle = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
				rsp_if.ready <= 1'b0;
			end else if (rx_cycle >= STEADY_START && rx_cycle < STEADY_END) begin
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= ($urandom_range(0, 99) >= 8);
			end
		end
	end

	// Offers one radicand and returns at the edge where it is accepted. A random gap may come
	// first unless the caller asks for a steady stream. Valid is never lowered and raised in
	// one step: with no gap the next radicand simply replaces the last one.
	task automatic send_radicand(input logic [isqrt_pkg::RADICAND_W-1:0] radicand,
		input bit steady);
		while (!steady && $urandom_range(0, 99) < 8) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.radicand <= radicand;
		do begin
			@(posedge clk);
		end while (!req_if.ready);
	endtask

	// Stops offering and waits until every pending root has come back. The first edge lets
	// the monitor record the radicand accepted at the edge where this task was called.
	task automatic drain_roots();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (roots.pending_roots.size() != 0)
			@(posedge clk);
	endtask

	// Random radicands shaped so that the compare sees both outcomes near its boundary:
	// full-range values, perfect squares and their neighbors, values of random bit length,
	// and values just under the top of the range.
	function automatic logic [isqrt_pkg::RADICAND_W-1:0] pick_radicand();
		int                               kind;
		logic [isqrt_pkg::RADICAND_W-1:0] base;
		logic [isqrt_pkg::RADICAND_W-1:0] root_guess;
		kind = $urandom_range(0, 99);
		base = {$urandom(), $urandom()};
		if (kind < 40) begin
			return base;
		end else if (kind < 75) begin
			root_guess = 64'($urandom() >> $urandom_range(0, 31));
			return root_guess * root_guess + 64'($urandom_range(0, 2)) - 64'd1;
		end else if (kind < 90) begin
			return base >> $urandom_range(0, 63);
		end else begin
			return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000));
		end
	endfunction

	initial begin
		roots = new();
		req_if.valid    = 1'b0;
		req_if.radicand = '0;
		arst_n          = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_radicands[i])
			send_radicand(corner_radicands[i], 1'b0);
		drain_roots();

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i == DRAIN_POINT)
				drain_roots();
			send_radicand(pick_radicand(), i >= SEND_STEADY_LO && i < SEND_STEADY_HI);
		end
		drain_roots();

		// Waiting past the latency catches any root beat the core should not produce.
		repeat (LATENCY_CYCLES + 5) @(posedge clk);
		if (roots.failures == 0 && roots.pending_roots.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
